@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define RCHB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("port check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define RCHB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("port check failed");

`endif

@@ rtl/core/rchb_pkg.sv @@
// Types, codes and constants of the RC pulse to H-bridge PWM driver.
package rchb_pkg;

  // pulse width counter size
  localparam int WidthBits = 12;
  // compare width, wide enough for the counter and the 11-bit thresholds
  localparam int CmpW = 17;

  localparam logic [WidthBits-1:0] CountMax = {WidthBits{1'b1}};

  localparam logic [CmpW-1:0] CenterUs = CmpW'(1500);
  localparam logic [CmpW-1:0] SpanUs   = CmpW'(500);

  // floor(d * 255 / 500) = (d * ScaleMul) >> ScaleShift for d < 500
  localparam int ScaleShift = 19;
  localparam int ProdW      = 27;
  localparam logic [ProdW-1:0] ScaleMul = ProdW'(267393);

  localparam logic [7:0] DutyMax = 8'd255;

  localparam logic [1:0] DirBrake = 2'd0;
  localparam logic [1:0] DirFwd   = 2'd1;
  localparam logic [1:0] DirRev   = 2'd2;

  localparam logic [3:0] GatesOff   = 4'd0;
  localparam logic [3:0] GatesFwd   = 4'd9;
  localparam logic [3:0] GatesRev   = 4'd6;
  localparam logic [3:0] GatesBrake = 4'd10;

  // register indexes on the APB port (paddr[3:2])
  localparam logic [1:0] RegFwdMin     = 2'd0;
  localparam logic [1:0] RegRevMax     = 2'd1;
  localparam logic [1:0] RegBrakeTicks = 2'd2;

  localparam int AddrW = 4;

  localparam logic [10:0] FwdMinReset     = 11'd1600;
  localparam logic [10:0] RevMaxReset     = 11'd1400;
  localparam logic [15:0] BrakeTicksReset = 16'd10000;

  typedef struct packed {
    logic rc_level;
    logic pwm_tick;
  } rchb_in_t;

  typedef struct packed {
    logic [3:0] gate_pattern;
    logic [1:0] drive_dir;
    logic [7:0] drive_duty;
    logic       pulse_done;
  } rchb_out_t;

endpackage

@@ rtl/core/rc_pulse_hbridge_pwm_driver_unit.sv @@
// RC servo pulse to H-bridge PWM driver: pulse measurement, direction, duty and gates.
// Usage:
//   Input channel: one beat per microsecond tick, carrying the sampled RC level and a
//   PWM-advance flag. Output channel: exactly one beat per input beat, with the gate
//   pattern, drive direction, duty and a pulse-done flag.
//   An accepted beat updates the state registers and the result register at the same
//   edge. Throughput is 1 beat per cycle while the receiver does not stall; the
//   per-tick update (edge handling, duty scaling by one constant multiply, PWM
//   compare) is combinational between the state and the result register.
//   The result register also serves as the buffer between the two sides: a new beat
//   is taken whenever the result register is empty or is being drained in the same
//   cycle. When the receiver stalls with a result waiting, in_stall_o goes high and
//   the waiting result holds.
//   Reset clears the pulse counter, PWM phase, hold counter, duty and direction
//   (brake) and loads the register defaults: forward above 1600 us, reverse below
//   1400 us, 10000 ticks of reversal brake. Registers must be written over APB only
//   while the block is idle, which the block does not enforce; pready is always high.
module rc_pulse_hbridge_pwm_driver_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  rchb_pkg::rchb_in_t          in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output rchb_pkg::rchb_out_t         out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rchb_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import rchb_pkg::*;

  // configuration
  logic [10:0] fwd_min_q;
  logic [10:0] rev_max_q;
  logic [15:0] brake_ticks_q;

  // tick state
  logic                 prev_level_q, prev_level_d;
  logic [WidthBits-1:0] pulse_count_q, pulse_count_d;
  logic [1:0]           dir_q, dir_d;
  logic [1:0]           pend_q, pend_d;
  logic [7:0]           duty_q, duty_d;
  logic [7:0]           phase_q, phase_d;
  logic [15:0]          hold_q, hold_d;

  logic      out_valid_q;
  rchb_out_t out_q, out_d;

  logic            in_accept;
  logic            cfg_write;
  logic [CmpW-1:0] width_x;
  logic [CmpW-1:0] diff;
  logic [ProdW-1:0] prod;
  logic [7:0]      duty_scaled;
  logic [1:0]      target;

  assign pready     = 1'b1;
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_accept  = in_valid_i & ~in_stall_o;
  assign cfg_write  = psel & penable & pwrite & pready;

  always_comb begin
    case (paddr[3:2])
      RegFwdMin:     prdata = 32'(fwd_min_q);
      RegRevMax:     prdata = 32'(rev_max_q);
      RegBrakeTicks: prdata = 32'(brake_ticks_q);
      default:       prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_min_q     <= FwdMinReset;
      rev_max_q     <= RevMaxReset;
      brake_ticks_q <= BrakeTicksReset;
    end else if (cfg_write) begin
      case (paddr[3:2])
        RegFwdMin:     fwd_min_q     <= pwdata[10:0];
        RegRevMax:     rev_max_q     <= pwdata[10:0];
        RegBrakeTicks: brake_ticks_q <= pwdata[15:0];
        default:       ;
      endcase
    end
  end

  // width of the finished pulse: the count holds while the input is low
  assign width_x = CmpW'(pulse_count_q);
  assign diff    = (width_x >= CenterUs) ? (width_x - CenterUs) : (CenterUs - width_x);
  assign prod    = ProdW'(diff[8:0]) * ScaleMul;
  assign duty_scaled = (diff >= SpanUs) ? DutyMax : prod[ScaleShift+7:ScaleShift];

  always_comb begin
    if (width_x > CmpW'(fwd_min_q)) begin
      target = DirFwd;
    end else if (width_x < CmpW'(rev_max_q)) begin
      target = DirRev;
    end else begin
      target = DirBrake;
    end
  end

  always_comb begin
    phase_d       = in_data_i.pwm_tick ? phase_q + 8'd1 : phase_q;
    hold_d        = hold_q;
    dir_d         = dir_q;
    pend_d        = pend_q;
    duty_d        = duty_q;
    pulse_count_d = pulse_count_q;
    prev_level_d  = in_data_i.rc_level;
    out_d.pulse_done = 1'b0;

    if (hold_q != 16'd0) begin
      hold_d = hold_q - 16'd1;
      if (hold_d == 16'd0) begin
        dir_d = pend_q;
      end
    end

    if (in_data_i.rc_level) begin
      if (!prev_level_q) begin
        pulse_count_d = WidthBits'(1);
      end else if (pulse_count_q != CountMax) begin
        pulse_count_d = pulse_count_q + WidthBits'(1);
      end
    end else if (prev_level_q) begin
      out_d.pulse_done = 1'b1;
      if (target == DirBrake) begin
        // deadband: brake now and drop any running hold
        duty_d = 8'd0;
        dir_d  = DirBrake;
        pend_d = DirBrake;
        hold_d = 16'd0;
      end else begin
        duty_d = duty_scaled;
        if (hold_d != 16'd0) begin
          pend_d = target;
        end else if ((dir_d == DirFwd && target == DirRev) ||
                     (dir_d == DirRev && target == DirFwd)) begin
          pend_d = target;
          hold_d = brake_ticks_q;
          dir_d  = (brake_ticks_q != 16'd0) ? DirBrake : target;
        end else begin
          dir_d  = target;
          pend_d = target;
        end
      end
    end

    if (dir_d == DirBrake) begin
      out_d.gate_pattern = GatesBrake;
    end else if (phase_d < duty_d) begin
      out_d.gate_pattern = (dir_d == DirFwd) ? GatesFwd : GatesRev;
    end else begin
      out_d.gate_pattern = GatesOff;
    end
    out_d.drive_dir  = dir_d;
    out_d.drive_duty = duty_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_level_q  <= 1'b0;
      pulse_count_q <= '0;
      dir_q         <= DirBrake;
      pend_q        <= DirBrake;
      duty_q        <= 8'd0;
      phase_q       <= 8'd0;
      hold_q        <= 16'd0;
    end else if (in_accept) begin
      prev_level_q  <= prev_level_d;
      pulse_count_q <= pulse_count_d;
      dir_q         <= dir_d;
      pend_q        <= pend_d;
      duty_q        <= duty_d;
      phase_q       <= phase_d;
      hold_q        <= hold_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ rtl/core/rchb_port_chk.sv @@
// Port-level checker for the RC pulse H-bridge driver, bound to the top level.
`include "assert_macros.svh"

module rchb_port_chk (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_stall_o,
  input  logic                        out_valid_o,
  input  logic                        out_stall_i,
  input  rchb_pkg::rchb_out_t         out_data_o
);
  import rchb_pkg::*;

  // a stalled result holds
  `RCHB_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))

  // the input side only stalls behind a waiting, stalled result
  `RCHB_ASSERT_IMP(a_stall_cause, in_stall_o, out_valid_o && out_stall_i)

  // brake keeps both low sides on
  `RCHB_ASSERT_IMP(a_brake_gates, out_valid_o && out_data_o.drive_dir == DirBrake,
                   out_data_o.gate_pattern == GatesBrake)

  // forward drive only ever shows the forward pattern or all off
  `RCHB_ASSERT_IMP(a_fwd_gates, out_valid_o && out_data_o.drive_dir == DirFwd,
                   out_data_o.gate_pattern == GatesFwd || out_data_o.gate_pattern == GatesOff)

endmodule

bind rc_pulse_hbridge_pwm_driver_unit rchb_port_chk u_rchb_port_chk (.*);

@@ tb/sv/rc_pulse_hbridge_pwm_driver_unit_test.sv @@
// Self-checking testbench of the RC pulse to H-bridge PWM driver unit.
module rc_pulse_hbridge_pwm_driver_unit_test;
  import rchb_pkg::*;

  // register index with no register behind it; writes there change nothing
  localparam logic [1:0] RegUnused = 2'd3;

  localparam rchb_out_t BrakeIdle = '{GatesBrake, DirBrake, 8'd0, 1'b0};
  localparam rchb_out_t BrakeDone = '{GatesBrake, DirBrake, 8'd0, 1'b1};

  typedef struct packed {
    logic       level;
    logic       tick;
    logic [3:0] reps;
    logic       pinned;  // take want as the expected beat, else use the predictor
    rchb_out_t  want;
  } tick_row_t;

  // run with forward above 3, reverse below 2, 3 ticks of reversal brake
  localparam tick_row_t DirectedRows [0:17] = '{
    '{1'b0, 1'b0, 4'd1, 1'b1, BrakeIdle},  // straight out of reset
    '{1'b0, 1'b1, 4'd1, 1'b1, BrakeIdle},  // phase moves, still brake
    '{1'b1, 1'b1, 4'd4, 1'b0, BrakeIdle},
    '{1'b0, 1'b0, 4'd1, 1'b0, BrakeIdle},  // width 4: forward from brake
    '{1'b1, 1'b1, 4'd1, 1'b0, BrakeIdle},
    '{1'b0, 1'b1, 4'd1, 1'b0, BrakeIdle},  // width 1: reversal, hold starts
    '{1'b0, 1'b0, 4'd3, 1'b0, BrakeIdle},  // hold runs out, reverse applied
    '{1'b1, 1'b0, 4'd4, 1'b0, BrakeIdle},
    '{1'b0, 1'b1, 4'd1, 1'b0, BrakeIdle},  // forward again: reversal
    '{1'b1, 1'b1, 4'd1, 1'b0, BrakeIdle},
    '{1'b0, 1'b0, 4'd1, 1'b0, BrakeIdle},  // edge while holding: pending only
    '{1'b0, 1'b1, 4'd1, 1'b0, BrakeIdle},
    '{1'b1, 1'b0, 4'd2, 1'b0, BrakeIdle},
    '{1'b0, 1'b1, 4'd1, 1'b1, BrakeDone},  // width 2: deadband
    '{1'b1, 1'b1, 4'd3, 1'b0, BrakeIdle},
    '{1'b0, 1'b0, 4'd1, 1'b1, BrakeDone},  // width 3: deadband
    '{1'b1, 1'b0, 4'd1, 1'b0, BrakeIdle},
    '{1'b0, 1'b1, 4'd1, 1'b0, BrakeIdle}   // reverse straight from brake
  };

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  rchb_in_t          in_data_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  rchb_out_t         out_data_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [AddrW-1:0]  paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  rc_pulse_hbridge_pwm_driver_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #5 clk_i = ~clk_i;

  // bridge model: limits and state
  logic [10:0]          m_fwd_min = FwdMinReset;
  logic [10:0]          m_rev_max = RevMaxReset;
  logic [15:0]          m_brake_ticks = BrakeTicksReset;
  logic                 m_prev = 1'b0;
  logic [WidthBits-1:0] m_width = '0;
  logic [1:0]           m_dir = DirBrake;
  logic [1:0]           m_pending = DirBrake;
  logic [7:0]           m_duty = '0;
  logic [7:0]           m_phase = '0;
  logic [15:0]          m_hold = '0;

  rchb_out_t bridge_beats_due [$];
  logic      pin_on = 1'b0;
  rchb_out_t pin_want = '0;
  int        tx_idle_pct = 0;
  int        rx_idle_pct = 0;
  int        mismatches = 0;
  int        beats_in = 0;
  int        beats_out = 0;
  int        settings_run = 0;

  function automatic rchb_out_t next_bridge_outputs(input rchb_in_t b);
    rchb_out_t  r;
    logic [1:0] tgt;
    int         w;
    int         diff;
    int         sc;
    r = '0;
    if (b.pwm_tick) m_phase = m_phase + 8'd1;
    if (m_hold != 16'd0) begin
      m_hold = m_hold - 16'd1;
      if (m_hold == 16'd0) m_dir = m_pending;
    end
    if (b.rc_level) begin
      if (!m_prev) m_width = WidthBits'(1);
      else if (m_width != CountMax) m_width = m_width + 1'b1;
    end else if (m_prev) begin
      r.pulse_done = 1'b1;
      w = int'(m_width);
      if (w > int'(m_fwd_min)) tgt = DirFwd;
      else if (w < int'(m_rev_max)) tgt = DirRev;
      else tgt = DirBrake;
      if (tgt == DirBrake) begin
        m_duty = '0;
        m_dir = DirBrake;
        m_pending = DirBrake;
        m_hold = '0;
      end else begin
        diff = (w >= int'(CenterUs)) ? w - int'(CenterUs) : int'(CenterUs) - w;
        sc = diff * int'(DutyMax) / int'(SpanUs);
        m_duty = (sc > int'(DutyMax)) ? DutyMax : 8'(sc);
        if (m_hold != 16'd0) begin
          m_pending = tgt;
        end else if ((m_dir == DirFwd && tgt == DirRev) ||
                     (m_dir == DirRev && tgt == DirFwd)) begin
          m_pending = tgt;
          m_hold = m_brake_ticks;
          m_dir = (m_hold != 16'd0) ? DirBrake : tgt;
        end else begin
          m_dir = tgt;
          m_pending = tgt;
        end
      end
    end
    m_prev = b.rc_level;
    if (m_dir == DirBrake) r.gate_pattern = GatesBrake;
    else if (m_phase < m_duty) r.gate_pattern = (m_dir == DirFwd) ? GatesFwd : GatesRev;
    else r.gate_pattern = GatesOff;
    r.drive_dir = m_dir;
    r.drive_duty = m_duty;
    return r;
  endfunction

  // predict at input acceptance, check at output acceptance
  always @(posedge clk_i) begin : scoreboard
    rchb_out_t pred;
    rchb_out_t want;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      pred = next_bridge_outputs(in_data_i);
      bridge_beats_due.push_back(pin_on ? pin_want : pred);
      beats_in++;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      beats_out++;
      if (bridge_beats_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output beat %p", out_data_o);
      end else begin
        want = bridge_beats_due.pop_front();
        if (out_data_o.gate_pattern !== want.gate_pattern ||
            out_data_o.drive_dir !== want.drive_dir ||
            out_data_o.drive_duty !== want.drive_duty ||
            out_data_o.pulse_done !== want.pulse_done) begin
          mismatches++;
          if (mismatches <= 10)
            $display("beat %0d mismatch: gates %0d/%0d dir %0d/%0d duty %0d/%0d done %0d/%0d",
                     beats_out, out_data_o.gate_pattern, want.gate_pattern,
                     out_data_o.drive_dir, want.drive_dir, out_data_o.drive_duty,
                     want.drive_duty, out_data_o.pulse_done, want.pulse_done);
        end
      end
    end
  end

  always @(negedge clk_i)
    out_stall_i <= (rx_idle_pct != 0) && ($urandom_range(0, 99) < rx_idle_pct);

  // all tasks below are entered and left at a falling edge with nothing driven there yet
  task automatic send_tick(input logic lvl, input logic tk);
    while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{rc_level: lvl, pwm_tick: tk};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (bridge_beats_due.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      RegFwdMin:     m_fwd_min = data[10:0];
      RegRevMax:     m_rev_max = data[10:0];
      RegBrakeTicks: m_brake_ticks = data[15:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
  endtask

  // upper bits carry junk that the block must drop
  task automatic load_limits(input int fwd, input int rev, input int brake);
    settle();
    write_reg(RegFwdMin, ($urandom() & ~32'h7FF) | 32'(fwd));
    write_reg(RegRevMax, ($urandom() & ~32'h7FF) | 32'(rev));
    write_reg(RegBrakeTicks, ($urandom() & ~32'hFFFF) | 32'(brake));
    write_reg(RegUnused, $urandom());
    settings_run++;
  endtask

  // short pulses aimed around the thresholds, with the odd glitch on the level
  task automatic run_pulses(input int budget);
    int   sent;
    int   gap;
    int   w;
    logic lv;
    sent = 0;
    while (sent < budget) begin
      gap = $urandom_range(1, 6);
      case ($urandom_range(0, 3))
        0: w = int'(m_fwd_min) + int'($urandom_range(0, 4)) - 2;
        1: w = int'(m_rev_max) + int'($urandom_range(0, 4)) - 2;
        default: w = $urandom_range(1, 40);
      endcase
      if (w < 1) w = 1;
      if (w > 64) w = $urandom_range(1, 64);
      for (int k = 0; k < gap + w; k++) begin
        lv = (k >= gap);
        if ($urandom_range(0, 15) == 0) lv = ~lv;
        send_tick(lv, 1'($urandom_range(0, 1)));
        sent++;
      end
    end
  endtask

  // one clean servo-length pulse followed by a low stretch
  task automatic run_long(input int w);
    repeat (w) send_tick(1'b1, 1'($urandom_range(0, 1)));
    repeat ($urandom_range(5, 40)) send_tick(1'b0, 1'($urandom_range(0, 1)));
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    tx_idle_pct = 24;
    rx_idle_pct = 78;
    load_limits(3, 2, 3);
    for (int r = 0; r < $size(DirectedRows); r++) begin
      pin_on <= DirectedRows[r].pinned;
      pin_want <= DirectedRows[r].want;
      repeat (DirectedRows[r].reps) send_tick(DirectedRows[r].level, DirectedRows[r].tick);
    end
    pin_on <= 1'b0;

    load_limits(12, 6, 5);
    run_pulses(60);
    load_limits(5, 9, 0);  // crossed thresholds, immediate reversal
    run_pulses(60);

    tx_idle_pct = 78;
    rx_idle_pct = 24;
    load_limits(20, 10, 65535);  // hold only ends through the deadband
    run_pulses(60);
    load_limits(2047, 0, 1);  // everything lands in the deadband
    run_pulses(60);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    load_limits(0, 2047, 7);
    run_pulses(60);
    load_limits(30, 8, 4);
    run_pulses(60);

    // one servo-length pulse inside the scaled duty range
    load_limits(1600, 1400, 300);
    run_long($urandom_range(1050, 1150));

    in_valid_i <= 1'b0;
    while (bridge_beats_due.size() != 0) @(negedge clk_i);
    repeat (5) @(posedge clk_i);
    if (bridge_beats_due.size() != 0) begin
      mismatches += bridge_beats_due.size();
      $display("%0d expected beats never came out", bridge_beats_due.size());
    end
    $display("ran %0d register settings, %0d ticks in, %0d beats checked",
             settings_run, beats_in, beats_out);
    $display("covered short and servo-length pulses, reversals, deadband and idle mixes");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
